>>> hw/rtl/slt_pkg.sv
package slt_pkg;

    localparam int NUM_LOCKS   = 4;
    localparam int COUNT_BITS  = 32;
    localparam int IDX_W       = $clog2(NUM_LOCKS);
    localparam int IN_IDX_W    = 2;
    localparam int SESS_W      = 64;
    localparam int CMD_W       = 3;
    localparam int OUT_COUNT_W = 32;

    typedef enum logic [CMD_W-1:0] {
        CMD_ACQUIRE = 3'd0,
        CMD_RELEASE = 3'd1,
        CMD_READ    = 3'd2,
        CMD_QUERY   = 3'd3,
        CMD_CLEANUP = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SWEEP
    } state_t;

    // table write request
    typedef struct packed {
        logic                  en;
        logic [IDX_W-1:0]      addr;
        logic                  held_we;
        logic                  held_val;
        logic                  count_inc;
        logic                  owner_we;
        logic [SESS_W-1:0]     owner;
    } tbl_wr_t;

    // table read data at the read address
    typedef struct packed {
        logic                  held;
        logic [COUNT_BITS-1:0] count;
        logic [COUNT_BITS-1:0] count_plus;
        logic [SESS_W-1:0]     owner;
    } tbl_rd_t;

    // one result item
    typedef struct packed {
        logic                   valid;
        logic                   failed;
        logic [OUT_COUNT_W-1:0] count;
        logic                   held;
    } result_t;

endpackage

>>> hw/rtl/slt_table.sv
module slt_table (
    input  logic                      clk,
    input  logic                      rst_n,
    input  slt_pkg::tbl_wr_t          wr,
    input  logic [slt_pkg::IDX_W-1:0] rd_addr,
    output slt_pkg::tbl_rd_t          rd
);
    import slt_pkg::*;

    logic                  held_reg  [NUM_LOCKS];
    logic [COUNT_BITS-1:0] count_reg [NUM_LOCKS];
    logic [SESS_W-1:0]     owner_reg [NUM_LOCKS];

    // single read port; a counter incrementer sits on it for the acquire result
    always_comb
    begin
        rd.held       = held_reg[rd_addr];
        rd.count      = count_reg[rd_addr];
        rd.count_plus = count_reg[rd_addr] + COUNT_BITS'(1);
        rd.owner      = owner_reg[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_LOCKS; i++)
            begin
                held_reg[i]  <= 1'b0;
                count_reg[i] <= '0;
                owner_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            if (wr.held_we)
                held_reg[wr.addr] <= wr.held_val;
            if (wr.count_inc)
                count_reg[wr.addr] <= count_reg[wr.addr] + COUNT_BITS'(1);
            if (wr.owner_we)
                owner_reg[wr.addr] <= wr.owner;
        end
    end

endmodule

>>> hw/rtl/slt_ctrl.sv
module slt_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [slt_pkg::CMD_W-1:0]    command,
    input  logic [slt_pkg::IN_IDX_W-1:0] lock_index,
    input  logic [slt_pkg::SESS_W-1:0]   session_id,
    output logic                         busy,
    input  slt_pkg::tbl_rd_t             rd,
    output logic [slt_pkg::IDX_W-1:0]    rd_addr,
    output slt_pkg::tbl_wr_t             wr,
    output slt_pkg::result_t             res
);
    import slt_pkg::*;

    state_t             state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [SESS_W-1:0]  sess_reg, sess_next;
    logic               owner_eq;

    // the one session comparator, shared by release and the cleanup sweep
    assign owner_eq = (rd.owner == sess_reg);
    assign rd_addr  = (state_reg == ST_SWEEP) ? ptr_reg : idx_reg;
    assign busy     = (state_reg != ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        idx_reg  <= idx_next;
        ptr_reg  <= ptr_next;
        sess_reg <= sess_next;
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        idx_next     = idx_reg;
        ptr_next     = ptr_reg;
        sess_next    = sess_reg;
        wr           = '0;
        wr.addr      = rd_addr;
        wr.owner     = sess_reg;
        res          = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next  = cmd_t'(command);
                    // depth is a power of two: index modulo depth is the low bits
                    idx_next  = IDX_W'(lock_index);
                    sess_next = session_id;
                    ptr_next  = '0;
                    state_next = (cmd_t'(command) == CMD_CLEANUP) ? ST_SWEEP : ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                res.valid  = 1'b1;
                state_next = ST_IDLE;
                unique case (cmd_reg)
                    CMD_ACQUIRE:
                    begin
                        res.held = 1'b1;
                        if (!rd.held)
                        begin
                            wr.en        = 1'b1;
                            wr.held_we   = 1'b1;
                            wr.held_val  = 1'b1;
                            wr.count_inc = 1'b1;
                            wr.owner_we  = 1'b1;
                            res.count    = OUT_COUNT_W'(rd.count_plus);
                        end
                        else
                        begin
                            res.failed = 1'b1;
                            res.count  = OUT_COUNT_W'(rd.count);
                        end
                    end
                    CMD_RELEASE:
                    begin
                        res.count = OUT_COUNT_W'(rd.count);
                        if (owner_eq)
                        begin
                            wr.en       = 1'b1;
                            wr.held_we  = 1'b1;
                            wr.held_val = 1'b0;
                            res.held    = 1'b0;
                        end
                        else
                        begin
                            res.failed = 1'b1;
                            res.held   = rd.held;
                        end
                    end
                    CMD_READ:
                    begin
                        res.count = OUT_COUNT_W'(rd.count);
                        res.held  = rd.held;
                    end
                    CMD_QUERY:
                        res.held = rd.held;
                    default:
                        res.held = 1'b0;    // unknown codes: all-zero result
                endcase
            end

            ST_SWEEP:
            begin
                if (owner_eq)
                begin
                    wr.en       = 1'b1;
                    wr.held_we  = 1'b1;
                    wr.held_val = 1'b0;
                end
                ptr_next = ptr_reg + IDX_W'(1);
                if (ptr_reg == IDX_W'(NUM_LOCKS - 1))
                begin
                    res.valid  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

>>> hw/rtl/session_lock_table_unit.sv
// Channel  | Signals                                   | Handshake
// ---------+-------------------------------------------+-------------------------------
// request  | command, lock_index, session_id           | taken at edge with start && !busy
// result   | failed, count_value, is_held              | done high one cycle, no stall
//
// Acquire, release, read and query latch the item, then read the lock entry,
// compare owners and write back.
// Cleanup latches the item, then the sequencer walks every lock through
// the single 64-bit owner comparator, one lock per cycle.
// The result shows on done the cycle after the last work cycle; busy has
// already dropped then, so the next item can be taken in that same cycle.
// Reset clears all held flags, counters and owners (owner 0).
module session_lock_table_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [slt_pkg::CMD_W-1:0]         command,
    input  logic [slt_pkg::IN_IDX_W-1:0]      lock_index,
    input  logic [slt_pkg::SESS_W-1:0]        session_id,
    output logic                              done,
    output logic                              failed,
    output logic [slt_pkg::OUT_COUNT_W-1:0]   count_value,
    output logic                              is_held
);
    import slt_pkg::*;

    tbl_wr_t                wr;
    tbl_rd_t                rd;
    logic [IDX_W-1:0]       rd_addr;
    result_t                res;

    logic                   done_reg;
    logic                   failed_reg;
    logic [OUT_COUNT_W-1:0] count_reg;
    logic                   held_reg;

    // sequencer: latches the item, drives the shared comparator and table writes
    slt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .command    (command),
        .lock_index (lock_index),
        .session_id (session_id),
        .busy       (busy),
        .rd         (rd),
        .rd_addr    (rd_addr),
        .wr         (wr),
        .res        (res)
    );

    // per-lock held flag, acquire counter and owner session
    slt_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .rd_addr (rd_addr),
        .rd      (rd)
    );

    // output register: result strobe is the only control bit here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= res.valid;
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            failed_reg <= res.failed;
            count_reg  <= res.count;
            held_reg   <= res.held;
        end
    end

    assign done        = done_reg;
    assign failed      = failed_reg;
    assign count_value = count_reg;
    assign is_held     = held_reg;

endmodule

>>> bench/session_lock_table_unit_tb.sv
module session_lock_table_unit_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import slt_pkg::*;

    // Command codes outside the defined set; the block must treat them as no-ops.
    localparam logic [CMD_W-1:0] CMD_RSVD_LO  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_MID = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI  = 3'd7;

    localparam int NUM_CODES    = 2 ** CMD_W;
    localparam int RANDOM_ITEMS = 1030;
    localparam int MAX_GAP      = 13;
    // No-acceptance limit: must outlast a cleanup sweep, plus the longest
    // sender gap, plus the result register. The limit leaves a wide margin.
    localparam int STALL_LIMIT  = 400;
    // After the last result: longer than a cleanup sweep.
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;
    localparam logic [SESS_W-1:0] SESS_ALL_ONES = {SESS_W{1'b1}};

    // One response from the lock table.
    typedef struct packed {
        logic                   failed;
        logic [OUT_COUNT_W-1:0] count;
        logic                   held;
    } lock_resp_t;

    // Shadow of the lock table plus the queue of responses still owed by the DUT.
    class lock_scoreboard;
        bit                  held_q  [NUM_LOCKS];
        bit [COUNT_BITS-1:0] acq_cnt [NUM_LOCKS];
        bit [SESS_W-1:0]     owner_q [NUM_LOCKS];
        lock_resp_t          pending_resps[$];
        int                  mismatches;
        int                  checked;
        int                  grants;
        int                  contentions;
        int                  release_denied;
        int                  cleanup_frees;

        // Apply one accepted item to the shadow table and queue its response.
        function void note_request(logic [CMD_W-1:0] cmd, logic [IN_IDX_W-1:0] idx_in,
                                   logic [SESS_W-1:0] sess);
            int         i;
            int         k;
            lock_resp_t r;
            i = int'(idx_in) % NUM_LOCKS;
            r = '0;
            case (cmd)
                CMD_ACQUIRE:
                begin
                    if (!held_q[i])
                    begin
                        held_q[i]  = 1'b1;
                        acq_cnt[i] = acq_cnt[i] + 1'b1;
                        owner_q[i] = sess;
                        grants++;
                    end
                    else
                    begin
                        r.failed = 1'b1;
                        contentions++;
                    end
                    r.count = OUT_COUNT_W'(acq_cnt[i]);
                    r.held  = held_q[i];
                end
                CMD_RELEASE:
                begin
                    // freeing an already-free lock by its recorded owner is fine
                    if (sess == owner_q[i])
                        held_q[i] = 1'b0;
                    else
                    begin
                        r.failed = 1'b1;
                        release_denied++;
                    end
                    r.count = OUT_COUNT_W'(acq_cnt[i]);
                    r.held  = held_q[i];
                end
                CMD_READ:
                begin
                    r.count = OUT_COUNT_W'(acq_cnt[i]);
                    r.held  = held_q[i];
                end
                CMD_QUERY:
                    r.held = held_q[i];
                CMD_CLEANUP:
                begin
                    for (k = 0; k < NUM_LOCKS; k++)
                    begin
                        if (owner_q[k] == sess)
                        begin
                            if (held_q[k])
                                cleanup_frees++;
                            held_q[k] = 1'b0;
                        end
                    end
                end
                default:
                    ;
            endcase
            pending_resps.push_back(r);
        endfunction

        function void check_result(logic f, logic [OUT_COUNT_W-1:0] c, logic h);
            lock_resp_t exp_r;
            if (pending_resps.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] ERROR: result with nothing pending: %s",
                             $realtime,
                             $sformatf("failed=%0b count=%0d held=%0b", f, c, h));
                return;
            end
            exp_r = pending_resps.pop_front();
            checked++;
            if (f !== exp_r.failed || c !== exp_r.count || h !== exp_r.held)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("[%0t] ERROR: result %0d: exp %s, got %s",
                             $realtime, checked,
                             $sformatf("failed=%0b count=%0d held=%0b",
                                       exp_r.failed, exp_r.count, exp_r.held),
                             $sformatf("failed=%0b count=%0d held=%0b", f, c, h));
            end
        endfunction
    endclass

    logic                   clk        = 1'b0;
    logic                   rst_n      = 1'b0;
    logic                   start      = 1'b0;
    logic [CMD_W-1:0]       command    = CMD_READ;
    logic [IN_IDX_W-1:0]    lock_index = '0;
    logic [SESS_W-1:0]      session_id = '0;
    logic                   busy;
    logic                   done;
    logic                   failed;
    logic [OUT_COUNT_W-1:0] count_value;
    logic                   is_held;

    lock_scoreboard         sb;
    logic [SESS_W-1:0]      sess_pool [6];
    int                     cmd_seen  [NUM_CODES];
    int                     no_gap_left;
    int                     idle_cycles;

    session_lock_table_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .command     (command),
        .lock_index  (lock_index),
        .session_id  (session_id),
        .done        (done),
        .failed      (failed),
        .count_value (count_value),
        .is_held     (is_held)
    );

    always #5 clk = ~clk;

    // Results last one cycle and cannot be stalled: sample done at every edge.
    // Reads here see pre-edge values since the DUT updates with nonblocking writes.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(failed, count_value, is_held);
    end

    // Watchdog: any accepted item or result restarts the count.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] ERROR: no activity for %0d cycles", $realtime, STALL_LIMIT);
                $display("session_lock_table_unit test failed");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [SESS_W-1:0] rand_session();
        return {$urandom, $urandom};
    endfunction

    // Mostly sessions from a small live pool so owners collide and releases
    // match; the rest are fresh 64-bit values.
    function automatic logic [SESS_W-1:0] pick_session();
        if ($urandom_range(0, 99) < 85)
            return sess_pool[$urandom_range(0, 5)];
        return rand_session();
    endfunction

    // Sender gap drawn per item; occasional bursts run back to back.
    task automatic sender_gap();
        int n;
        if (no_gap_left > 0)
        begin
            no_gap_left--;
            n = 0;
        end
        else
        begin
            n = $urandom_range(0, MAX_GAP);
            if ($urandom_range(0, 39) == 0)
                no_gap_left = $urandom_range(10, 40);
        end
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Present one item and hold it until the DUT takes it (start && !busy).
    // start stays high into the next item when the next gap is zero.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [IN_IDX_W-1:0] idx,
                             input logic [SESS_W-1:0] sess);
        sender_gap();
        start      <= 1'b1;
        command    <= cmd;
        lock_index <= idx;
        session_id <= sess;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(cmd, idx, sess);
        cmd_seen[cmd]++;
    endtask

    task automatic send_random_item();
        int                  r;
        logic [CMD_W-1:0]    cmd;
        logic [IN_IDX_W-1:0] idx;
        logic [SESS_W-1:0]   sess;
        r    = $urandom_range(0, 99);
        idx  = IN_IDX_W'($urandom_range(0, 3));
        sess = pick_session();
        if (r < 28)
            cmd = CMD_ACQUIRE;
        else if (r < 56)
        begin
            cmd = CMD_RELEASE;
            // half the releases come from the current owner so locks free up
            if ($urandom_range(0, 1) == 1)
                sess = sb.owner_q[int'(idx) % NUM_LOCKS];
        end
        else if (r < 68)
            cmd = CMD_READ;
        else if (r < 78)
            cmd = CMD_QUERY;
        else if (r < 93)
        begin
            cmd = CMD_CLEANUP;
            if ($urandom_range(0, 1) == 1)
                sess = sb.owner_q[$urandom_range(0, NUM_LOCKS - 1)];
        end
        else
            cmd = CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
        // slowly rotate the pool so new owners keep appearing
        if ($urandom_range(0, 24) == 0)
            sess_pool[$urandom_range(2, 5)] = rand_session();
        send_item(cmd, idx, sess);
    endtask

    initial
    begin
        int                i;
        logic [SESS_W-1:0] s_a;
        logic [SESS_W-1:0] s_b;

        sb          = new();
        no_gap_left = 0;
        idle_cycles = 0;
        for (i = 0; i < NUM_CODES; i++)
            cmd_seen[i] = 0;
        sess_pool[0] = '0;
        sess_pool[1] = SESS_ALL_ONES;
        for (i = 2; i < 6; i++)
            sess_pool[i] = rand_session();
        s_a = 64'h0123_4567_89ab_cdef;
        s_b = 64'haaaa_aaaa_aaaa_aaaa;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // --- directed part ---
        // owners reset to zero: session 0 may release a never-acquired lock
        send_item(CMD_RELEASE, 2'd0, '0);
        // free lock, different session: denied
        send_item(CMD_RELEASE, 2'd1, SESS_ALL_ONES);
        send_item(CMD_QUERY,   2'd2, '0);
        send_item(CMD_READ,    2'd3, SESS_ALL_ONES);
        send_item(CMD_ACQUIRE, 2'd0, SESS_ALL_ONES);
        // contention on a held lock
        send_item(CMD_ACQUIRE, 2'd0, s_a);
        // release by non-owner while held
        send_item(CMD_RELEASE, 2'd0, s_a);
        send_item(CMD_ACQUIRE, 2'd1, SESS_ALL_ONES);
        send_item(CMD_ACQUIRE, 2'd2, s_a);
        send_item(CMD_ACQUIRE, 2'd3, '0);
        send_item(CMD_QUERY,   2'd1, s_b);
        // cleanup frees locks 0 and 1 only
        send_item(CMD_CLEANUP, 2'd2, SESS_ALL_ONES);
        send_item(CMD_READ,    2'd0, '0);
        // owner releasing an already-free lock is no error
        send_item(CMD_RELEASE, 2'd0, SESS_ALL_ONES);
        // reserved codes leave state alone and report zeros
        send_item(CMD_RSVD_LO,  2'd2, s_a);
        send_item(CMD_RSVD_MID, 2'd3, '0);
        send_item(CMD_RSVD_HI,  2'd1, SESS_ALL_ONES);
        send_item(CMD_RELEASE, 2'd2, s_a);
        // cleanup by session 0 frees lock 3
        send_item(CMD_CLEANUP, 2'd0, '0);
        send_item(CMD_READ,    2'd3, s_b);
        send_item(CMD_ACQUIRE, 2'd3, s_b);
        send_item(CMD_RELEASE, 2'd3, ~s_b);
        // cleanup with no matching owner changes nothing
        send_item(CMD_CLEANUP, 2'd1, ~s_b);
        send_item(CMD_QUERY,   2'd3, '0);
        send_item(CMD_RELEASE, 2'd3, s_b);

        // --- random part ---
        for (i = 0; i < RANDOM_ITEMS; i++)
            send_random_item();

        start <= 1'b0;
        while (sb.pending_resps.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered: acquire %0d, release %0d, read %0d, query %0d, cleanup %0d, %s",
                 cmd_seen[CMD_ACQUIRE], cmd_seen[CMD_RELEASE], cmd_seen[CMD_READ],
                 cmd_seen[CMD_QUERY], cmd_seen[CMD_CLEANUP],
                 $sformatf("reserved %0d", cmd_seen[CMD_RSVD_LO] + cmd_seen[CMD_RSVD_MID]
                                           + cmd_seen[CMD_RSVD_HI]));
        $display("Results checked %0d: grants %0d, contentions %0d, denied releases %0d, %s",
                 sb.checked, sb.grants, sb.contentions, sb.release_denied,
                 $sformatf("locks freed by cleanup %0d, mismatches %0d",
                           sb.cleanup_frees, sb.mismatches));
        if (sb.mismatches == 0 && sb.pending_resps.size() == 0)
            $display("session_lock_table_unit test passed");
        else
            $display("session_lock_table_unit test failed");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/slt_pkg.sv
hw/rtl/slt_table.sv
hw/rtl/slt_ctrl.sv
hw/rtl/session_lock_table_unit.sv
bench/session_lock_table_unit_tb.sv
